// ===== rtl/core/wavp_pkg.sv =====
// Shared types, codes and constants of the WAVE header parser.
package wavp_pkg;

	typedef enum logic [3:0] {
		S_RIFF,
		S_CHDR,
		S_FMT,
		S_SKIP,
		S_DATA,
		S_MUL1,
		S_MUL2,
		S_DIVGO,
		S_DIV,
		S_ERR_HDR,
		S_ERR_PCM,
		S_ERR_MISS
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HDR,
		OP_FMT
	} op_t;

	localparam logic [2:0] ST_HEADER  = 3'd0;
	localparam logic [2:0] ST_AUDIO   = 3'd1;
	localparam logic [2:0] ST_DONE    = 3'd2;
	localparam logic [2:0] ST_DROP    = 3'd3;
	localparam logic [2:0] ST_BAD_HDR = 3'd4;
	localparam logic [2:0] ST_NOT_PCM = 3'd5;
	localparam logic [2:0] ST_MISSING = 3'd6;

	localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
	localparam logic [31:0] FMT_KEEP  = 32'd16;
	localparam logic [15:0] PCM_CODE  = 16'd1;
	localparam logic [9:0]  MS_PER_S  = 10'd1000;
	localparam int          DIVD_W    = 42;
	localparam int          DCNT_W    = $clog2(DIVD_W);

	typedef struct packed {
		op_t  op;
		logic idx_clr;
		logic idx_inc;
		logic fmt_clear;
		logic fmt_seen_set;
		logic data_latch;
		logic audio_sel;
		logic mul1;
		logic mul2;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic riff_bad;
		logic idx_ge7;
		logic idx_ge11;
		logic at_lim;
		logic at_end;
		logic fmt_bad;
		logic tag_fmt;
		logic tag_data;
		logic len_zero;
		logic fmt_seen;
		logic deliv_more;
		logic div_done;
	} sts_t;

	function automatic logic [7:0] riff_byte(input logic [1:0] sel);
		logic [7:0] r;
		unique case (sel)
			2'd0: r = 8'h52;
			2'd1: r = 8'h49;
			2'd2: r = 8'h46;
			default: r = 8'h46;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] wave_byte(input logic [1:0] sel);
		logic [7:0] r;
		unique case (sel)
			2'd0: r = 8'h57;
			2'd1: r = 8'h41;
			2'd2: r = 8'h56;
			default: r = 8'h45;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/wavp_if.sv =====
// Stream interfaces for file bytes in and parse results out.
interface wavp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface wavp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  audio_byte;
	logic        is_last_audio;
	logic [15:0] chan_count;
	logic [31:0] samp_freq;
	logic [15:0] samp_width;
	logic [31:0] data_bytes;
	logic [31:0] play_ms;
	logic [31:0] bytes_delivered;

	modport source (output valid, output status, output audio_byte, output is_last_audio,
		output chan_count, output samp_freq, output samp_width, output data_bytes,
		output play_ms, output bytes_delivered, input ready);
	modport sink (input valid, input status, input audio_byte, input is_last_audio,
		input chan_count, input samp_freq, input samp_width, input data_bytes,
		input play_ms, input bytes_delivered, output ready);
endinterface

// ===== rtl/core/wavp_div.sv =====
// Radix-2 restoring divider for the duration, one quotient bit per cycle.
module wavp_div
	import wavp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [31:0]       divisor,
	output logic              done,
	output logic [31:0]       quotient
);

	logic              busy_q;
	logic              done_q;
	logic              zero_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [31:0]       rem_q;
	logic [31:0]       dvs_q;
	logic [DIVD_W-1:0] quo_q;
	logic [32:0]       rem_sh;
	logic [32:0]       diff;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			zero_q <= divisor == 32'd0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? 32'd0 : quo_q[31:0];

endmodule

// ===== rtl/core/wavp_datapath.sv =====
// Byte counters, chunk fields, fmt values and duration arithmetic.
module wavp_datapath
	import wavp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [7:0]  audio_byte,
	output logic        is_last_audio,
	output logic [15:0] chan_count,
	output logic [31:0] samp_freq,
	output logic [15:0] samp_width,
	output logic [31:0] data_bytes,
	output logic [31:0] play_ms,
	output logic [31:0] bytes_delivered
);

	logic [31:0]       idx_q;
	logic [31:0]       len_q;
	logic [31:0]       tag_q;
	logic              fmt_seen_q;
	logic [15:0]       format_q;
	logic [15:0]       channels_q;
	logic [31:0]       rate_q;
	logic [15:0]       bits_q;
	logic [31:0]       data_len_q;
	logic [31:0]       prod1_q;
	logic [31:0]       bytes_per_sec_q;
	logic [DIVD_W-1:0] dividend_q;
	logic [31:0]       duration_q;
	logic [31:0]       deliv_q;
	logic [7:0]        audio_q;
	logic              last_q;

	logic [31:0]       len_full;
	logic [15:0]       fmt_new;
	logic              deliv_final;
	logic [47:0]       p1_full;
	logic [44:0]       p2_full;
	logic [DIVD_W-1:0] divd_full;
	logic              div_done;
	logic [31:0]       div_quo;

	assign len_full    = {in_byte, len_q[23:0]};
	assign fmt_new     = (idx_q >= 32'd2) ? format_q :
		(idx_q[0] ? {in_byte, format_q[7:0]} : {format_q[15:8], in_byte});
	assign deliv_final = (deliv_q + 32'd1) == data_len_q;
	assign p1_full     = rate_q * channels_q;
	assign p2_full     = prod1_q * bits_q[15:3];
	assign divd_full   = data_len_q * MS_PER_S;

	always_comb begin
		sts.riff_bad = 1'b0;
		if (idx_q < 32'd4)
			sts.riff_bad = in_byte != riff_byte(idx_q[1:0]);
		else if (idx_q >= 32'd8)
			sts.riff_bad = in_byte != wave_byte(idx_q[1:0]);
		sts.idx_ge7    = idx_q >= 32'd7;
		sts.idx_ge11   = idx_q >= 32'd11;
		sts.at_end     = idx_q == (len_q - 32'd1);
		sts.at_lim     = (len_q < FMT_KEEP) ? sts.at_end : (idx_q == (FMT_KEEP - 32'd1));
		sts.fmt_bad    = fmt_new != PCM_CODE;
		sts.tag_fmt    = tag_q == TAG_FMT;
		sts.tag_data   = tag_q == TAG_DATA;
		sts.len_zero   = len_full == 32'd0;
		sts.fmt_seen   = fmt_seen_q;
		sts.deliv_more = deliv_q < data_len_q;
		sts.div_done   = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q           <= '0;
			len_q           <= '0;
			tag_q           <= '0;
			fmt_seen_q      <= 1'b0;
			format_q        <= '0;
			channels_q      <= '0;
			rate_q          <= '0;
			bits_q          <= '0;
			data_len_q      <= '0;
			bytes_per_sec_q <= '0;
			duration_q      <= '0;
			deliv_q         <= '0;
			audio_q         <= '0;
			last_q          <= 1'b0;
		end else begin
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 32'd1;

			if (cmd.op == OP_HDR) begin
				if (!idx_q[2]) begin
					if (idx_q[1:0] == 2'd0)
						tag_q <= {24'd0, in_byte};
					else
						tag_q[{idx_q[1:0], 3'b000} +: 8] <= in_byte;
				end else begin
					if (idx_q[1:0] == 2'd0)
						len_q <= {24'd0, in_byte};
					else
						len_q[{idx_q[1:0], 3'b000} +: 8] <= in_byte;
				end
			end

			if (cmd.fmt_clear) begin
				format_q   <= '0;
				channels_q <= '0;
				rate_q     <= '0;
				bits_q     <= '0;
			end else if (cmd.op == OP_FMT) begin
				if (idx_q < 32'd2)
					format_q <= fmt_new;
				else if (idx_q < 32'd4)
					channels_q[{idx_q[0], 3'b000} +: 8] <= in_byte;
				else if (idx_q < 32'd8)
					rate_q[{idx_q[1:0], 3'b000} +: 8] <= in_byte;
				else if (idx_q == 32'd14 || idx_q == 32'd15)
					bits_q[{idx_q[0], 3'b000} +: 8] <= in_byte;
			end

			if (cmd.fmt_seen_set)
				fmt_seen_q <= 1'b1;

			if (cmd.data_latch) begin
				data_len_q <= len_full;
				deliv_q    <= '0;
			end else if (cmd.audio_sel) begin
				deliv_q <= deliv_q + 32'd1;
			end

			if (cmd.mul2)
				bytes_per_sec_q <= p2_full[31:0];
			if (div_done)
				duration_q <= div_quo;

			if (cmd.out_load) begin
				audio_q <= cmd.audio_sel ? in_byte : 8'd0;
				last_q  <= cmd.audio_sel && deliv_final;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod1_q    <= p1_full[31:0];
			dividend_q <= divd_full;
		end
	end

	wavp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend_q),
		.divisor  (bytes_per_sec_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign audio_byte      = audio_q;
	assign is_last_audio   = last_q;
	assign chan_count      = channels_q;
	assign samp_freq       = rate_q;
	assign samp_width      = bits_q;
	assign data_bytes      = data_len_q;
	assign play_ms         = duration_q;
	assign bytes_delivered = deliv_q;

endmodule

// ===== rtl/core/wavp_ctrl.sv =====
// Parse state machine, handshake control and result status register.
module wavp_ctrl
	import wavp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t     state_q;
	state_t     state_d;
	logic       out_valid_q;
	logic [2:0] status_q;
	logic [2:0] status_d;
	logic       out_free;
	logic       busy;
	logic       fire;
	logic       hdr_end;

	assign out_free = !out_valid_q || out_ready;
	assign busy     = state_q inside {S_MUL1, S_MUL2, S_DIVGO, S_DIV};
	assign in_ready = out_free && !busy;
	assign fire     = in_valid && in_ready;
	assign hdr_end  = state_q == S_CHDR && sts.idx_ge7;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_RIFF: begin
				if (fire) begin
					if (sts.riff_bad)
						state_d = S_ERR_HDR;
					else if (sts.idx_ge11)
						state_d = in_last ? S_ERR_MISS : S_CHDR;
					else if (in_last)
						state_d = S_ERR_HDR;
				end
			end
			S_CHDR: begin
				if (fire) begin
					if (sts.idx_ge7) begin
						if (sts.tag_fmt)
							state_d = sts.len_zero ? S_ERR_PCM : (in_last ? S_ERR_MISS : S_FMT);
						else if (sts.tag_data)
							state_d = sts.fmt_seen ? S_MUL1 : S_ERR_MISS;
						else
							state_d = in_last ? S_ERR_MISS : (sts.len_zero ? S_CHDR : S_SKIP);
					end else if (in_last) begin
						state_d = S_ERR_MISS;
					end
				end
			end
			S_FMT: begin
				if (fire) begin
					if (sts.at_lim && sts.fmt_bad)
						state_d = S_ERR_PCM;
					else if (in_last)
						state_d = S_ERR_MISS;
					else if (sts.at_end)
						state_d = S_CHDR;
				end
			end
			S_SKIP: begin
				if (fire) begin
					if (in_last)
						state_d = S_ERR_MISS;
					else if (sts.at_end)
						state_d = S_CHDR;
				end
			end
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_DIVGO;
			S_DIVGO: state_d = S_DIV;
			S_DIV: begin
				if (sts.div_done)
					state_d = S_DATA;
			end
			S_DATA, S_ERR_HDR, S_ERR_PCM, S_ERR_MISS: state_d = state_q;
			default: state_d = S_RIFF;
		endcase
	end

	always_comb begin
		cmd = '0;
		if (fire) begin
			unique case (state_q)
				S_CHDR:  cmd.op = OP_HDR;
				S_FMT:   cmd.op = OP_FMT;
				default: cmd.op = OP_NONE;
			endcase
		end
		cmd.idx_clr      = fire && (state_d != state_q || hdr_end);
		cmd.idx_inc      = fire && !cmd.idx_clr;
		cmd.fmt_clear    = fire && hdr_end && sts.tag_fmt;
		cmd.data_latch   = fire && hdr_end && !sts.tag_fmt && sts.tag_data;
		cmd.fmt_seen_set = fire && state_q == S_FMT && sts.at_lim && !sts.fmt_bad;
		cmd.audio_sel    = fire && state_q == S_DATA && sts.deliv_more;
		cmd.mul1         = state_q == S_MUL1;
		cmd.mul2         = state_q == S_MUL2;
		cmd.div_start    = state_q == S_DIVGO;
		cmd.out_load     = (fire && state_d != S_MUL1) || (state_q == S_DIV && sts.div_done);

		unique case (state_d)
			S_ERR_HDR:  status_d = ST_BAD_HDR;
			S_ERR_PCM:  status_d = ST_NOT_PCM;
			S_ERR_MISS: status_d = ST_MISSING;
			S_DATA: begin
				if (state_q == S_DIV)
					status_d = ST_DONE;
				else
					status_d = sts.deliv_more ? ST_AUDIO : ST_DROP;
			end
			default: status_d = ST_HEADER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RIFF;
			out_valid_q <= 1'b0;
			status_q    <= ST_HEADER;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

// ===== rtl/core/wav_header_parser_and_data_gate.sv =====
// Top level of the WAVE header parser and audio data gate.
// Feed the file one byte per beat; every byte gives exactly one result beat, in order.
// Header, chunk-skip, audio and dropped bytes are taken one per cycle while the output is
// not stalled; a registered output stage lets a new byte be accepted in the same cycle
// the previous result is taken. The byte that completes the data chunk header gets its
// header-done result once S_MUL1 and S_MUL2 have formed the byte rate and the scaled
// data size, S_DIVGO has loaded and S_DIV has run the radix-2 duration divider.
// Errors (bad header, not PCM, missing chunk) hold until reset and repeat on every byte.
module wav_header_parser_and_data_gate
	import wavp_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	wavp_in_if.sink     feed,
	wavp_out_if.source  result
);

	cmd_t cmd;
	sts_t sts;

	wavp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feed.valid),
		.in_last   (feed.in_last),
		.in_ready  (feed.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (result.status),
		.sts       (sts),
		.cmd       (cmd)
	);

	wavp_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_byte         (feed.in_byte),
		.cmd             (cmd),
		.sts             (sts),
		.audio_byte      (result.audio_byte),
		.is_last_audio   (result.is_last_audio),
		.chan_count      (result.chan_count),
		.samp_freq       (result.samp_freq),
		.samp_width      (result.samp_width),
		.data_bytes      (result.data_bytes),
		.play_ms         (result.play_ms),
		.bytes_delivered (result.bytes_delivered)
	);

endmodule

// ===== tb/wav_header_parser_and_data_gate_tb.sv =====
// Self-checking testbench for the WAVE header parser and audio data gate.
module wav_header_parser_and_data_gate_tb;
	import wavp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS = 1000;
	localparam int DRAIN_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [31:0] RIFF_LE = 32'h4646_4952;
	localparam logic [31:0] WAVE_LE = 32'h4556_4157;

	typedef enum int {
		FILE_OK,
		FILE_BAD_TAG,
		FILE_SHORT_RIFF,
		FILE_EARLY_END,
		FILE_NOT_PCM,
		FILE_EMPTY_FMT,
		FILE_NO_FMT
	} file_kind_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} file_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  audio;
		logic        last_audio;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] sample_bits;
		logic [31:0] size;
		logic [31:0] duration;
		logic [31:0] delivered;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n;

	wavp_in_if feed_if ();
	wavp_out_if result_if ();

	wav_header_parser_and_data_gate DUT (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_if),
		.result(result_if)
	);

	always #1 clk = ~clk;

	file_beat_t file_q[$];
	parse_result_t pending_results[$];
	file_beat_t next_beat;
	int failures = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int idle_run = 0;
	int phase_seed;

	// parser state
	state_t walk = S_RIFF;
	logic [31:0] walk_idx = '0;
	logic [31:0] chunk_len = '0;
	logic [31:0] chunk_id = '0;
	logic have_fmt = 1'b0;
	logic [15:0] fmt_code = '0;
	logic [15:0] chans = '0;
	logic [31:0] rate = '0;
	logic [15:0] sample_bits = '0;
	logic [31:0] data_len = '0;
	logic [31:0] bytes_per_sec = '0;
	logic [31:0] dur_ms = '0;
	logic [31:0] delivered = '0;
	logic [2:0] stuck_status = ST_HEADER;

	function automatic logic [2:0] trap(input logic [2:0] code);
		stuck_status = code;
		case (code)
			ST_BAD_HDR: walk = S_ERR_HDR;
			ST_NOT_PCM: walk = S_ERR_PCM;
			default: walk = S_ERR_MISS;
		endcase
		return code;
	endfunction

	function automatic logic [2:0] close_chunk_header(input logic last);
		if (chunk_id == TAG_FMT) begin
			fmt_code = '0;
			chans = '0;
			rate = '0;
			sample_bits = '0;
			if (chunk_len == 0)
				return trap(ST_NOT_PCM);
			walk = S_FMT;
			walk_idx = '0;
			return last ? trap(ST_MISSING) : ST_HEADER;
		end
		if (chunk_id == TAG_DATA) begin
			data_len = chunk_len;
			if (!have_fmt)
				return trap(ST_MISSING);
			bytes_per_sec = rate * 32'(chans) * 32'(sample_bits / 16'd8);
			if (bytes_per_sec == 0)
				dur_ms = '0;
			else
				dur_ms = 32'((64'(data_len) * 64'(MS_PER_S)) / 64'(bytes_per_sec));
			delivered = '0;
			walk = S_DATA;
			walk_idx = '0;
			return ST_DONE;
		end
		walk = (chunk_len == 0) ? S_CHDR : S_SKIP;
		walk_idx = '0;
		return last ? trap(ST_MISSING) : ST_HEADER;
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b, input logic last);
		parse_result_t r;
		logic [31:0] i;
		logic [31:0] lim;
		logic [31:0] wide;
		logic bad;
		r = '0;
		r.status = ST_HEADER;
		i = walk_idx;
		wide = {24'd0, b};
		case (walk)
			S_RIFF: begin
				bad = 1'b0;
				if (i < 4)
					bad = b != RIFF_LE[8 * i[1:0] +: 8];
				else if (i >= 8)
					bad = b != WAVE_LE[8 * i[1:0] +: 8];
				if (bad)
					r.status = trap(ST_BAD_HDR);
				else if (i >= 11) begin
					walk = S_CHDR;
					walk_idx = '0;
					if (last)
						r.status = trap(ST_MISSING);
				end else if (last)
					r.status = trap(ST_BAD_HDR);
				else
					walk_idx = i + 1;
			end
			S_CHDR: begin
				if (i < 4) begin
					if (i == 0)
						chunk_id = '0;
					chunk_id |= wide << (8 * i[1:0]);
				end else begin
					if (i == 4)
						chunk_len = '0;
					chunk_len |= wide << (8 * i[1:0]);
				end
				if (i >= 7)
					r.status = close_chunk_header(last);
				else begin
					walk_idx = i + 1;
					if (last)
						r.status = trap(ST_MISSING);
				end
			end
			S_FMT: begin
				lim = (chunk_len < FMT_KEEP) ? chunk_len : FMT_KEEP;
				if (i < 2)
					fmt_code |= 16'(wide << (8 * i[0]));
				else if (i < 4)
					chans |= 16'(wide << (8 * i[0]));
				else if (i < 8)
					rate |= wide << (8 * i[1:0]);
				else if (i == 14 || i == 15)
					sample_bits |= 16'(wide << (8 * i[0]));
				if (i == lim - 1 && fmt_code != PCM_CODE)
					r.status = trap(ST_NOT_PCM);
				else begin
					if (i == lim - 1)
						have_fmt = 1'b1;
					if (i == chunk_len - 1) begin
						walk = S_CHDR;
						walk_idx = '0;
					end else
						walk_idx = i + 1;
					if (last)
						r.status = trap(ST_MISSING);
				end
			end
			S_SKIP: begin
				if (i == chunk_len - 1) begin
					walk = S_CHDR;
					walk_idx = '0;
				end else
					walk_idx = i + 1;
				if (last)
					r.status = trap(ST_MISSING);
			end
			S_DATA: begin
				if (delivered < data_len) begin
					delivered = delivered + 1;
					r.status = ST_AUDIO;
					r.audio = b;
					r.last_audio = delivered == data_len;
				end else
					r.status = ST_DROP;
			end
			default: r.status = stuck_status;
		endcase
		r.channels = chans;
		r.rate = rate;
		r.sample_bits = sample_bits;
		r.size = data_len;
		r.duration = dur_ms;
		r.delivered = delivered;
		return r;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic l);
		file_beat_t fb;
		fb.b = b;
		fb.l = l;
		file_q.push_back(fb);
	endtask

	task automatic push_le(input logic [31:0] v, input int n);
		for (int k = 0; k < n; k++)
			push_byte(v[8 * k +: 8], 1'b0);
	endtask

	task automatic push_fmt(input logic [15:0] code);
		logic [31:0] len;
		logic [31:0] rt;
		logic [15:0] ch;
		logic [15:0] bt;
		logic [7:0] b;
		case ($urandom_range(0, 4))
			0, 1: len = 16;
			2: len = 18;
			3: len = $urandom_range(1, 15);
			default: len = $urandom_range(17, 40);
		endcase
		case ($urandom_range(0, 3))
			0: ch = 16'h0000;
			1: ch = 16'hFFFF;
			2: ch = 16'($urandom_range(1, 8));
			default: ch = 16'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: rt = 32'h0;
			1: rt = 32'hFFFF_FFFF;
			2: rt = 32'd44100;
			3: rt = 32'd8000;
			default: rt = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0: bt = 16'd0;
			1: bt = 16'd8;
			2: bt = 16'd16;
			3: bt = 16'hFFFF;
			4: bt = 16'($urandom_range(1, 7));
			default: bt = 16'($urandom);
		endcase
		push_le(TAG_FMT, 4);
		push_le(len, 4);
		for (int k = 0; k < len; k++) begin
			case (k)
				0: b = code[7:0];
				1: b = code[15:8];
				2: b = ch[7:0];
				3: b = ch[15:8];
				4, 5, 6, 7: b = rt[8 * (k - 4) +: 8];
				14: b = bt[7:0];
				15: b = bt[15:8];
				default: b = 8'($urandom);
			endcase
			push_byte(b, 1'b0);
		end
	endtask

	task automatic push_skip_chunk();
		logic [31:0] tag;
		logic [31:0] len;
		tag = $urandom;
		if ($urandom_range(0, 3) == 0)
			tag = ($urandom_range(0, 1) ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(0, 31));
		if (tag == TAG_FMT || tag == TAG_DATA)
			tag ^= 32'h80;
		len = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 21));
		push_le(tag, 4);
		push_le(len, 4);
		repeat (len)
			push_byte(8'($urandom), 1'b0);
	endtask

	task automatic build_file();
		file_kind_t kind;
		file_beat_t fb;
		logic [15:0] code;
		logic [31:0] dlen;
		int v;
		int pos;
		int room;
		int hdr_end;
		v = $urandom_range(0, 12);
		kind = (v > 6) ? FILE_OK : file_kind_t'(v);
		push_le(RIFF_LE, 4);
		push_le($urandom, 4);
		push_le(WAVE_LE, 4);
		repeat ($urandom_range(0, 3)) begin
			if (kind != FILE_NO_FMT && $urandom_range(0, 1))
				push_fmt(PCM_CODE);
			else
				push_skip_chunk();
		end
		if (kind == FILE_NOT_PCM) begin
			code = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
			if (code == PCM_CODE)
				code = 16'd3;
			push_fmt(code);
		end
		if (kind == FILE_EMPTY_FMT) begin
			push_le(TAG_FMT, 4);
			push_le(32'd0, 4);
		end
		if (kind != FILE_NO_FMT)
			push_fmt(PCM_CODE);
		if ($urandom_range(0, 1))
			push_skip_chunk();
		room = ITEMS - file_q.size() - 8;
		case ($urandom_range(0, 5))
			0: dlen = 32'd0;
			1: dlen = room;
			2: dlen = $urandom_range(1, room - 1);
			3: dlen = 32'hFFFF_FFFF;
			4: dlen = $urandom;
			default: dlen = $urandom_range(1, 40);
		endcase
		push_le(TAG_DATA, 4);
		push_le(dlen, 4);
		hdr_end = file_q.size() - 1;
		repeat (room)
			push_byte(8'($urandom), $urandom_range(0, 15) == 0);
		case (kind)
			FILE_BAD_TAG: begin
				pos = $urandom_range(0, 7);
				if (pos >= 4)
					pos += 4;
				fb = file_q[pos];
				fb.b ^= 8'($urandom_range(1, 255));
				file_q[pos] = fb;
			end
			FILE_SHORT_RIFF, FILE_EARLY_END: begin
				pos = (kind == FILE_SHORT_RIFF) ? $urandom_range(0, 11)
					: $urandom_range(11, hdr_end - 1);
				fb = file_q[pos];
				fb.l = 1'b1;
				file_q[pos] = fb;
			end
			default: ;
		endcase
	endtask

	function automatic int idle_pct(input logic sender, input int done);
		case ((phase_seed + done * 4 / ITEMS) % 4)
			0: return 0;
			1: return sender ? 69 : 0;
			2: return sender ? 0 : 69;
			default: return 34;
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	task automatic check_result();
		parse_result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual status %0d",
				$time, result_if.status);
			failures++;
		end else begin
			want = pending_results.pop_front();
			compare_field("status", want.status, result_if.status);
			compare_field("audio_byte", want.audio, result_if.audio_byte);
			compare_field("is_last_audio", want.last_audio, result_if.is_last_audio);
			compare_field("chan_count", want.channels, result_if.chan_count);
			compare_field("samp_freq", want.rate, result_if.samp_freq);
			compare_field("samp_width", want.sample_bits, result_if.samp_width);
			compare_field("data_bytes", want.size, result_if.data_bytes);
			compare_field("play_ms", want.duration, result_if.play_ms);
			compare_field("bytes_delivered", want.delivered, result_if.bytes_delivered);
		end
	endtask

	// driver: predict on each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_if.valid <= 1'b0;
			feed_if.in_byte <= '0;
			feed_if.in_last <= 1'b0;
		end else begin
			if (feed_if.valid && feed_if.ready) begin
				pending_results.push_back(parse_byte(feed_if.in_byte, feed_if.in_last));
				bytes_sent++;
			end
			if (!feed_if.valid || feed_if.ready) begin
				if (file_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1, bytes_sent)) begin
					next_beat = file_q.pop_front();
					feed_if.valid <= 1'b1;
					feed_if.in_byte <= next_beat.b;
					feed_if.in_last <= next_beat.l;
				end else
					feed_if.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				check_result();
				results_seen++;
			end
			result_if.ready <= $urandom_range(0, 99) >= idle_pct(1'b0, results_seen);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready))
				idle_run <= 0;
			else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end else
				idle_run <= idle_run + 1;
		end
	end

	initial begin
		feed_if.valid = 1'b0;
		feed_if.in_byte = '0;
		feed_if.in_last = 1'b0;
		result_if.ready = 1'b0;
		arst_n = 1'b0;
		phase_seed = $urandom_range(0, 3);
		build_file();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (file_q.size() != 0 || feed_if.valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
